// ===== rtl/core/frame_rate_statistics_macros.svh =====
// ----------------------------------------------------------------------------
// frame rate statistics assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_STATISTICS_MACROS_SVH
`define FRAME_RATE_STATISTICS_MACROS_SVH

// property holds at every clock edge outside reset
`define FRS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/frs_pkg.sv =====
// ----------------------------------------------------------------------------
// frs_pkg
// types and constants shared by the frame rate statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

  localparam int unsigned STAT_W     = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned DVD_W      = 64;
  localparam int unsigned DCNT_W     = 7;
  localparam int unsigned TPS_W      = 30;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TPS_W-1:0]  TPS_RESET   = 30'd1000000;
  localparam logic [STAT_W-1:0] HITCH_RESET = 32'd12800;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HITCH_THRESHOLD  = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_UPDATE,
    ST_DIV_MEAN,
    ST_MEAN,
    ST_PUBLISH
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/frame_rate_statistics.sv =====
// ----------------------------------------------------------------------------
// frame_rate_statistics
// frame interval, rate, min/max/mean rate and hitch counting
// ----------------------------------------------------------------------------
// Each input word is a frame-start timestamp; each one returns exactly one
// result word with the statistics after the update. The first word only
// stores the timestamp and skips the divider. Every later word passes
// through one shared radix-2 restoring divider that first forms the rate,
// one quotient bit per cycle over the 30 + FRAC_BITS bit numerator, and
// then the mean, one bit per cycle over the 64-bit rate sum. Input ready is
// low from the accepted word until its result is loaded into the output
// register; a result waiting there is held until taken. Configuration
// writes are taken in any cycle.
`default_nettype none

module frame_rate_statistics
  import frs_pkg::*;
#(
  parameter int unsigned STAMP_BITS = 48,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [STAMP_BITS-1:0] timestamp_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       stats_valid_o,
  output logic [STAT_W-1:0]          frame_interval_o,
  output logic [STAT_W-1:0]          current_rate_o,
  output logic [STAT_W-1:0]          lowest_rate_o,
  output logic [STAT_W-1:0]          highest_rate_o,
  output logic [STAT_W-1:0]          mean_rate_o,
  output logic [STAT_W-1:0]          frame_total_o,
  output logic [STAT_W-1:0]          hitch_total_o
);

  localparam int unsigned NUM_W = TPS_W + FRAC_BITS;

  state_e state_q, state_d;

  logic [TPS_W-1:0]      tps_q;
  logic [STAT_W-1:0]     hitch_thr_q;
  logic                  have_prev_q;
  logic [STAMP_BITS-1:0] prev_q;
  logic [STAT_W-1:0]     interval_q;
  logic [STAT_W-1:0]     rate_q;
  logic [STAT_W-1:0]     min_q;
  logic [STAT_W-1:0]     max_q;
  logic [SUM_W-1:0]      sum_q;
  logic [STAT_W-1:0]     mean_q;
  logic [STAT_W-1:0]     frames_q;
  logic [STAT_W-1:0]     hitches_q;
  logic                  out_valid_q;

  logic [STAT_W-1:0]     dsr_q;
  logic [STAT_W-1:0]     rem_q;
  logic [DVD_W-1:0]      dvd_q;
  logic [DCNT_W-1:0]     dcnt_q;

  logic [STAT_W-1:0]     o_interval_q, o_rate_q, o_min_q, o_max_q;
  logic [STAT_W-1:0]     o_mean_q, o_frames_q, o_hitches_q;

  logic in_fire, div_step, div_last, out_load, first_item;

  // interval from the incoming stamp
  logic [DVD_W-1:0]  diff;
  logic [STAT_W-1:0] interval_c;
  logic [NUM_W-1:0]  num_c;

  assign diff = DVD_W'(timestamp_i) - DVD_W'(prev_q);
  always_comb begin
    if (timestamp_i <= prev_q) begin
      interval_c = STAT_W'(1);
    end else if (|diff[DVD_W-1:STAT_W]) begin
      interval_c = '1;
    end else begin
      interval_c = diff[STAT_W-1:0];
    end
  end
  assign num_c = NUM_W'(tps_q) << FRAC_BITS;

  // shared divider step
  logic [STAT_W:0]   rem_sh;
  logic [STAT_W+1:0] rem_sub;
  logic              rem_ge;

  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign rem_ge  = ~rem_sub[STAT_W+1];

  // quotient saturation and statistics update
  logic [STAT_W-1:0] quot_sat;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_c;
  logic [STAT_W-1:0] frames_c;
  logic [STAT_W-1:0] hitches_inc;

  assign quot_sat    = (|dvd_q[DVD_W-1:STAT_W]) ? '1 : dvd_q[STAT_W-1:0];
  assign sum_add     = {1'b0, sum_q} + (SUM_W+1)'(quot_sat);
  assign sum_c       = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign frames_c    = (&frames_q) ? frames_q : frames_q + STAT_W'(1);
  assign hitches_inc = (&hitches_q) ? hitches_q : hitches_q + STAT_W'(1);
  assign first_item  = (frames_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = have_prev_q ? ST_DIV_RATE : ST_PUBLISH;
        end
      end
      ST_DIV_RATE: begin
        if (div_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE:   state_d = ST_DIV_MEAN;
      ST_DIV_MEAN: begin
        if (div_last) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN:     state_d = ST_PUBLISH;
      ST_PUBLISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cfg_ready_o = 1'b1;
    div_step    = (state_q == ST_DIV_RATE) || (state_q == ST_DIV_MEAN);
    div_last    = div_step && (dcnt_q == DCNT_W'(1));
    out_load    = (state_q == ST_PUBLISH) && (!out_valid_q || out_ready_i);
  end

  assign in_fire = in_valid_i && in_ready_o;

  // control state, configuration and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tps_q       <= TPS_RESET;
      hitch_thr_q <= HITCH_RESET;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      interval_q  <= '0;
      rate_q      <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      frames_q    <= '0;
      hitches_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TICKS_PER_SECOND: tps_q       <= cfg_data_i[TPS_W-1:0];
          REG_HITCH_THRESHOLD:  hitch_thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        have_prev_q <= 1'b1;
        prev_q      <= timestamp_i;
        if (have_prev_q) begin
          interval_q <= interval_c;
        end
      end
      if (state_q == ST_UPDATE) begin
        rate_q   <= quot_sat;
        frames_q <= frames_c;
        sum_q    <= sum_c;
        if (first_item || quot_sat < min_q) begin
          min_q <= quot_sat;
        end
        if (first_item || quot_sat > max_q) begin
          max_q <= quot_sat;
        end
        if (quot_sat < hitch_thr_q) begin
          hitches_q <= hitches_inc;
        end
      end
      if (state_q == ST_MEAN) begin
        mean_q <= quot_sat;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider datapath and output word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rem_q  <= '0;
      dsr_q  <= interval_c;
      dvd_q  <= {num_c, {(DVD_W-NUM_W){1'b0}}};
      dcnt_q <= DCNT_W'(NUM_W);
    end else if (state_q == ST_UPDATE) begin
      rem_q  <= '0;
      dsr_q  <= frames_c;
      dvd_q  <= sum_c;
      dcnt_q <= DCNT_W'(DVD_W);
    end else if (div_step) begin
      rem_q  <= rem_ge ? rem_sub[STAT_W-1:0] : rem_sh[STAT_W-1:0];
      dvd_q  <= {dvd_q[DVD_W-2:0], rem_ge};
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
    if (out_load) begin
      o_interval_q <= interval_q;
      o_rate_q     <= rate_q;
      o_min_q      <= min_q;
      o_max_q      <= max_q;
      o_mean_q     <= mean_q;
      o_frames_q   <= frames_q;
      o_hitches_q  <= hitches_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stats_valid_o    = (o_frames_q != '0);
  assign frame_interval_o = o_interval_q;
  assign current_rate_o   = o_rate_q;
  assign lowest_rate_o    = o_min_q;
  assign highest_rate_o   = o_max_q;
  assign mean_rate_o      = o_mean_q;
  assign frame_total_o    = o_frames_q;
  assign hitch_total_o    = o_hitches_q;

endmodule

`default_nettype wire

// ===== rtl/core/frs_checker.sv =====
// ----------------------------------------------------------------------------
// frs_checker
// port-level assertions for frame_rate_statistics, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_rate_statistics_macros.svh"

module frs_checker
  import frs_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              stats_valid_o,
  input wire logic [STAT_W-1:0] lowest_rate_o,
  input wire logic [STAT_W-1:0] highest_rate_o,
  input wire logic [STAT_W-1:0] frame_total_o,
  input wire logic [STAT_W-1:0] hitch_total_o
);

  logic out_stall;
  assign out_stall = out_valid_o && !out_ready_i;

  `FRS_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_stall, out_valid_o, "result word dropped while stalled")
  `FRS_ASSERT_NEXT(a_out_word_hold, clk_i, rst_ni, out_stall, $stable(frame_total_o) && $stable(hitch_total_o), "result word changed while stalled")
  `FRS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken again before result")
  `FRS_ASSERT(a_stats_valid_total, clk_i, rst_ni, !out_valid_o || (stats_valid_o == (frame_total_o != '0)), "stats flag disagrees with frame total")
  `FRS_ASSERT(a_counts_ordered, clk_i, rst_ni, !out_valid_o || ((hitch_total_o <= frame_total_o) && (!stats_valid_o || (lowest_rate_o <= highest_rate_o))), "hitches exceed frames or min above max")

endmodule

bind frame_rate_statistics frs_checker u_frs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .stats_valid_o  (stats_valid_o),
  .lowest_rate_o  (lowest_rate_o),
  .highest_rate_o (highest_rate_o),
  .frame_total_o  (frame_total_o),
  .hitch_total_o  (hitch_total_o)
);

`default_nettype wire

// ===== tb/frame_rate_statistics_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_statistics_tb
// self-checking bench: frame stamps in, statistics words checked one by one
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own interval, rate, min/max/mean and hitch
// state and predicts the statistics word for every accepted frame stamp.
// A short directed run covers the first frame, repeated and backward stamps,
// long intervals, rate saturation, zero and full-scale tick rates and the
// threshold edge. Random phases follow, each with its own register setting,
// mostly frame-like intervals mixed with repeats, steps back and long jumps.
// The sender works in bursts with gaps and the receiver stalls by pattern.
// ----------------------------------------------------------------------------

module frame_rate_statistics_tb;
  import frs_pkg::*;

  localparam int unsigned STAMP_W   = 48;
  localparam int unsigned RATE_FRAC = 8;
  localparam logic [63:0] MAX32     = 64'hFFFF_FFFF;

  typedef struct packed {
    logic              stats_valid;
    logic [STAT_W-1:0] interval;
    logic [STAT_W-1:0] rate;
    logic [STAT_W-1:0] lowest;
    logic [STAT_W-1:0] highest;
    logic [STAT_W-1:0] mean;
    logic [STAT_W-1:0] frames;
    logic [STAT_W-1:0] hitches;
  } frame_stats_t;

  typedef enum logic [1:0] {
    HOLD_READY,
    COIN_FLIP,
    EVERY_FOURTH,
    LONG_STALL
  } stall_e;

  class frame_stats_board;
    logic [TPS_W-1:0]   tps;
    logic [STAT_W-1:0]  threshold;
    bit                 seen_first;
    logic [STAMP_W-1:0] last_stamp;
    logic [63:0]        span_q, rate_q, low_q, high_q, sum_q, mean_q;
    logic [63:0]        frames_q, hitches_q;
    frame_stats_t       due[$];
    int unsigned        mismatches, checked, saturated, hitched;

    function new();
      tps        = TPS_RESET;
      threshold  = HITCH_RESET;
      seen_first = 1'b0;
      last_stamp = '0;
      span_q     = '0;
      rate_q     = '0;
      low_q      = '0;
      high_q     = '0;
      sum_q      = '0;
      mean_q     = '0;
      frames_q   = '0;
      hitches_q  = '0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TICKS_PER_SECOND) tps = data[TPS_W-1:0];
      else if (idx == REG_HITCH_THRESHOLD) threshold = data;
    endfunction

    function void note_stamp(logic [STAMP_W-1:0] ts);
      frame_stats_t e;
      bit           opening;
      if (seen_first) begin
        opening = (frames_q == 0);
        span_q = (ts <= last_stamp) ? 64'd1 : 64'(ts) - 64'(last_stamp);
        if (span_q > MAX32) span_q = MAX32;
        rate_q = (64'(tps) << RATE_FRAC) / span_q;
        if (rate_q > MAX32) begin
          rate_q = MAX32;
          saturated++;
        end
        if (opening || rate_q < low_q) low_q = rate_q;
        if (opening || rate_q > high_q) high_q = rate_q;
        frames_q = (frames_q >= MAX32) ? MAX32 : frames_q + 1;
        sum_q = (sum_q > ~64'd0 - rate_q) ? ~64'd0 : sum_q + rate_q;
        mean_q = sum_q / frames_q;
        if (mean_q > MAX32) mean_q = MAX32;
        if (rate_q < 64'(threshold)) begin
          hitches_q = (hitches_q >= MAX32) ? MAX32 : hitches_q + 1;
          hitched++;
        end
      end
      seen_first = 1'b1;
      last_stamp = ts;
      e.stats_valid = (frames_q != 0);
      e.interval    = span_q[STAT_W-1:0];
      e.rate        = rate_q[STAT_W-1:0];
      e.lowest      = low_q[STAT_W-1:0];
      e.highest     = high_q[STAT_W-1:0];
      e.mean        = mean_q[STAT_W-1:0];
      e.frames      = frames_q[STAT_W-1:0];
      e.hitches     = hitches_q[STAT_W-1:0];
      due.push_back(e);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void cmp(string name, logic [STAT_W-1:0] got, logic [STAT_W-1:0] exp);
      if (got !== exp)
        report($sformatf("%s got 0x%08h expected 0x%08h (word %0d)", name, got, exp, checked));
    endfunction

    function void check_result(frame_stats_t got);
      frame_stats_t exp;
      if (due.size() == 0) begin
        report("statistics word with no frame stamp pending");
        return;
      end
      exp = due.pop_front();
      cmp("stats_valid", 32'(got.stats_valid), 32'(exp.stats_valid));
      cmp("frame_interval", got.interval, exp.interval);
      cmp("current_rate", got.rate, exp.rate);
      cmp("lowest_rate", got.lowest, exp.lowest);
      cmp("highest_rate", got.highest, exp.highest);
      cmp("mean_rate", got.mean, exp.mean);
      cmp("frame_total", got.frames, exp.frames);
      cmp("hitch_total", got.hitches, exp.hitches);
      checked++;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic [STAMP_W-1:0]    timestamp_i = '0;
  logic                  out_ready_i = 1'b1;
  logic                  cfg_ready_o;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  stats_valid_o;
  logic [STAT_W-1:0]     frame_interval_o;
  logic [STAT_W-1:0]     current_rate_o;
  logic [STAT_W-1:0]     lowest_rate_o;
  logic [STAT_W-1:0]     highest_rate_o;
  logic [STAT_W-1:0]     mean_rate_o;
  logic [STAT_W-1:0]     frame_total_o;
  logic [STAT_W-1:0]     hitch_total_o;

  frame_stats_board   board = new();
  logic [STAMP_W-1:0] stamp_cursor = '0;
  int unsigned        burst_left   = 0;
  int unsigned        sent         = 0;
  int unsigned        settings     = 0;

  stall_e      stall_mode = HOLD_READY;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  logic [1:0]  beat       = '0;

  frame_rate_statistics #(
    .STAMP_BITS(STAMP_W),
    .FRAC_BITS (RATE_FRAC)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .timestamp_i     (timestamp_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .stats_valid_o   (stats_valid_o),
    .frame_interval_o(frame_interval_o),
    .current_rate_o  (current_rate_o),
    .lowest_rate_o   (lowest_rate_o),
    .highest_rate_o  (highest_rate_o),
    .mean_rate_o     (mean_rate_o),
    .frame_total_o   (frame_total_o),
    .hitch_total_o   (hitch_total_o)
  );

  always #4 clk_i = ~clk_i;

  // receiver stall pattern
  always @(posedge clk_i) begin
    beat <= beat + 2'd1;
    if (mode_left == 0) begin
      stall_mode <= stall_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      HOLD_READY:   out_ready_i <= 1'b1;
      COIN_FLIP:    out_ready_i <= ($urandom_range(0, 3) != 0);
      EVERY_FOURTH: out_ready_i <= (beat == 2'd0);
      default: begin
        if (hold_left == 0) begin
          out_ready_i <= ~out_ready_i;
          hold_left   <= out_ready_i ? $urandom_range(1, 150) : $urandom_range(1, 4);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result('{stats_valid_o, frame_interval_o, current_rate_o, lowest_rate_o,
                           highest_rate_o, mean_rate_o, frame_total_o, hitch_total_o});
  end

  task automatic send_stamp(input logic [STAMP_W-1:0] ts);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 8);
        2:       gap = $urandom_range(9, 60);
        default: gap = $urandom_range(60, 120);
      endcase
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    timestamp_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_stamp(ts);
    stamp_cursor = ts;
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.apply_reg(idx, data);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] tps_word,
                              input logic [CFG_DATA_W-1:0] thr_word);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_TICKS_PER_SECOND, tps_word, 1'b0);
      write_reg(REG_HITCH_THRESHOLD, thr_word, 1'b1);
    end else begin
      write_reg(REG_HITCH_THRESHOLD, thr_word, 1'b0);
      write_reg(REG_TICKS_PER_SECOND, tps_word, 1'b1);
    end
    settings++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [STAMP_W-1:0] next_stamp();
    logic [63:0] delta;
    int unsigned pick;
    int unsigned fps;
    pick = $urandom_range(0, 99);
    fps  = $urandom_range(15, 240);
    if (pick < 55) begin
      delta = 64'(board.tps) / fps;
      delta = delta + 64'($urandom_range(0, 32'(delta >> 3)));
      if (delta == 0) delta = 64'($urandom_range(1, 64));
    end else if (pick < 65) begin
      delta = 64'($urandom_range(1, 16));
    end else if (pick < 72) begin
      delta = 64'd0;
    end else if (pick < 79) begin
      delta = -64'($urandom_range(1, 1000000));
    end else if (pick < 87) begin
      delta = {16'h0, 16'($urandom_range(1, 65535)), 32'($urandom)};
    end else if (pick < 93) begin
      delta = MAX32 + 64'($urandom_range(0, 1));
    end else begin
      delta = {16'h0, 16'($urandom), 32'($urandom)} - 64'(stamp_cursor);
    end
    return stamp_cursor + delta[STAMP_W-1:0];
  endfunction

  initial begin
    logic [TPS_W-1:0]  tps;
    logic [STAT_W-1:0] thr;
    int unsigned       count;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: first frame, repeats, steps back, threshold edge, long spans
    send_stamp(48'd0);
    send_stamp(48'd0);
    send_stamp(48'd16667);
    send_stamp(48'd36667);
    send_stamp(48'd56668);
    send_stamp(48'd10);
    send_stamp(48'hFFFF_FFFF_FFFF);
    send_stamp(48'hFFFF_FFFF_FFFF);
    send_stamp(48'h0000_0000_0000);
    send_stamp(48'h0001_0000_0000);
    send_stamp(48'h0001_FFFF_FFFF);
    send_stamp(48'h5555_5555_5555);
    send_stamp(48'hAAAA_AAAA_AAAA);
    drain();

    // full-scale tick rate: rate saturates on short spans
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_stamp(stamp_cursor + 48'd1);
    send_stamp(stamp_cursor + 48'd3);
    send_stamp(stamp_cursor + 48'd1000);
    drain();

    // zero tick rate
    program_regs(32'h0000_0000, 32'h0000_0000);
    send_stamp(stamp_cursor + 48'd1);
    send_stamp(stamp_cursor + 48'd500);
    drain();

    // slowest tick rate against a threshold of one
    program_regs(32'h0000_0001, 32'h0000_0001);
    send_stamp(stamp_cursor + 48'd1);
    send_stamp(stamp_cursor + 48'd300);
    drain();

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0:       tps = 30'd1;
        1:       tps = 30'h3FFF_FFFF;
        2:       tps = 30'($urandom_range(1000, 10000000));
        3:       tps = 30'($urandom_range(1, 1000000000));
        4:       tps = 30'd1000000;
        default: tps = 30'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       thr = 32'($urandom);
        1:       thr = ($urandom_range(0, 1)) ? 32'h0 : 32'hFFFF_FFFF;
        default: thr = 32'((64'(tps) << RATE_FRAC) / $urandom_range(20, 120));
      endcase
      program_regs({2'($urandom), tps}, thr);
      count = $urandom_range(90, 110);
      for (int i = 0; i < count; i++) begin
        send_stamp(next_stamp());
        if ($urandom_range(0, 149) == 0) drain();
      end
      drain();
    end

    repeat (120) @(posedge clk_i);
    $display("checked %0d statistics words from %0d frame stamps over %0d register settings",
             board.checked, sent, settings);
    $display("%0d words with a saturated rate, %0d with a new hitch",
             board.saturated, board.hitched);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #11000000;
    $display("timed out with %0d statistics words outstanding", board.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/frs_pkg.sv
rtl/core/frame_rate_statistics.sv
rtl/core/frs_checker.sv
tb/frame_rate_statistics_tb.sv
